FILE: rtl/core/hdc_pkg.sv
// Shared constants and types for the hyperboloid distance core.
package hdc_pkg;

   localparam int HDC_FRAC_BITS = 16;
   localparam int COORD_W       = 32;
   localparam int CURV_W        = 24;
   localparam logic [CURV_W-1:0] CURV_RESET = 24'h010000;
   localparam int PROD_W        = 64;
   localparam int PP_W          = PROD_W / 2 + CURV_W;
   localparam int ARG_W         = PROD_W + CURV_W;
   localparam int X_W           = 56;
   localparam int RAD_W         = 2 * X_W;
   localparam int BIG_EXP       = 24;
   localparam int SMALL_OFF     = 32;
   localparam int LOG_FRAC      = 40;
   localparam int LOG_INT_W     = 7;
   localparam int LG_W          = LOG_INT_W + LOG_FRAC;
   localparam int MANT_W        = 63;
   localparam int DIST_W        = 32;
   localparam logic [31:0] LN2_Q32 = 32'd2977044472;

   // Control bits that travel with every pipeline slot.
   typedef struct packed {
      logic valid;
      logic zero;
      logic nh;
   } hdc_ctl_type;

endpackage

FILE: rtl/core/hdc_arg.sv
// Argument stages: Minkowski product, curvature scaling and the radicand x*x - 1.
module hdc_arg
   import hdc_pkg::*;
#(
   parameter int FRAC_BITS = HDC_FRAC_BITS
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic [CURV_W-1:0]   curv,
   input  logic                in_valid,
   input  logic [COORD_W-1:0]  first_x,
   input  logic [COORD_W-1:0]  first_y,
   input  logic [COORD_W-1:0]  first_z,
   input  logic [COORD_W-1:0]  second_x,
   input  logic [COORD_W-1:0]  second_y,
   input  logic [COORD_W-1:0]  second_z,
   output hdc_ctl_type         out_ctl,
   output logic [ARG_W-1:0]    out_arg,
   output logic [X_W-1:0]      out_x,
   output logic                out_big,
   output logic [RAD_W-1:0]    out_rad
);

   localparam int Q       = 2 * FRAC_BITS + 16;
   localparam int SHIFT   = Q - 32;
   localparam int BIG_POS = Q + BIG_EXP;
   localparam logic [X_W-1:0] ONE_Q32 = X_W'(1) << 32;

   function automatic logic [COORD_W-1:0] mag(input logic [COORD_W-1:0] v);
      mag = v[COORD_W-1] ? (~v + 1'b1) : v;
   endfunction

   // Stage 1: magnitudes of the three products.
   hdc_ctl_type ctl1_in, ctl1_ff;
   logic [PROD_W-1:0] pz1_in, px1_in, py1_in, pz1_ff, px1_ff, py1_ff;
   logic nz1_in, nx1_in, ny1_in, nz1_ff, nx1_ff, ny1_ff;

   always_comb begin
      ctl1_in.valid = in_valid;
      ctl1_in.zero  = (curv == '0);
      ctl1_in.nh    = (curv == '0);
      pz1_in = PROD_W'(mag(first_z)) * PROD_W'(mag(second_z));
      px1_in = PROD_W'(mag(first_x)) * PROD_W'(mag(second_x));
      py1_in = PROD_W'(mag(first_y)) * PROD_W'(mag(second_y));
      nz1_in = first_z[COORD_W-1] ^ second_z[COORD_W-1];
      nx1_in = ~(first_x[COORD_W-1] ^ second_x[COORD_W-1]);
      ny1_in = ~(first_y[COORD_W-1] ^ second_y[COORD_W-1]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
      end else if (en) begin
         ctl1_ff <= ctl1_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pz1_ff <= pz1_in;
         px1_ff <= px1_in;
         py1_ff <= py1_in;
         nz1_ff <= nz1_in;
         nx1_ff <= nx1_in;
         ny1_ff <= ny1_in;
      end
   end

   // Stage 2: signed sum as a positive and a negative part.
   hdc_ctl_type ctl2_in, ctl2_ff;
   logic [PROD_W-1:0] pos, neg, diff2_in, diff2_ff;

   always_comb begin
      pos = (nz1_ff ? '0 : pz1_ff) + (nx1_ff ? '0 : px1_ff) + (ny1_ff ? '0 : py1_ff);
      neg = (nz1_ff ? pz1_ff : '0) + (nx1_ff ? px1_ff : '0) + (ny1_ff ? py1_ff : '0);
      diff2_in = pos - neg;
      ctl2_in = ctl1_ff;
      ctl2_in.zero = ctl1_ff.zero | (pos <= neg);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl2_ff <= '0;
      end else if (en) begin
         ctl2_ff <= ctl2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         diff2_ff <= diff2_in;
      end
   end

   // Stage 3: partial products of the difference and the curvature.
   hdc_ctl_type ctl3_ff;
   logic [PP_W-1:0] ah3_in, al3_in, ah3_ff, al3_ff;

   always_comb begin
      ah3_in = PP_W'(diff2_ff[PROD_W-1:PROD_W/2]) * PP_W'(curv);
      al3_in = PP_W'(diff2_ff[PROD_W/2-1:0]) * PP_W'(curv);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl3_ff <= '0;
      end else if (en) begin
         ctl3_ff <= ctl2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ah3_ff <= ah3_in;
         al3_ff <= al3_in;
      end
   end

   // Stage 4: the argument, the range split and the truncated x.
   hdc_ctl_type ctl4_in, ctl4_ff;
   logic [ARG_W-1:0] arg4_in, arg4_ff;
   logic [X_W-1:0] x4_in, x4_ff;
   logic big4_in, big4_ff;

   always_comb begin
      arg4_in = (ARG_W'(ah3_ff) << (PROD_W / 2)) + ARG_W'(al3_ff);
      big4_in = ((arg4_in >> BIG_POS) != '0);
      x4_in   = X_W'(arg4_in >> SHIFT);
      ctl4_in = ctl3_ff;
      ctl4_in.zero = ctl3_ff.zero | (!big4_in && (x4_in <= ONE_Q32));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl4_ff <= '0;
      end else if (en) begin
         ctl4_ff <= ctl4_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         arg4_ff <= arg4_in;
         x4_ff   <= x4_in;
         big4_ff <= big4_in;
      end
   end

   // Stage 5: partial products of x squared.
   hdc_ctl_type ctl5_ff;
   logic [ARG_W-1:0] arg5_ff;
   logic [X_W-1:0] x5_ff;
   logic big5_ff;
   logic [47:0] hh5_in, hh5_ff;
   logic [55:0] hl5_in, hl5_ff;
   logic [63:0] ll5_in, ll5_ff;

   always_comb begin
      hh5_in = 48'(x4_ff[X_W-1:32]) * 48'(x4_ff[X_W-1:32]);
      hl5_in = 56'(x4_ff[X_W-1:32]) * 56'(x4_ff[31:0]);
      ll5_in = 64'(x4_ff[31:0]) * 64'(x4_ff[31:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl5_ff <= '0;
      end else if (en) begin
         ctl5_ff <= ctl4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         arg5_ff <= arg4_ff;
         x5_ff   <= x4_ff;
         big5_ff <= big4_ff;
         hh5_ff  <= hh5_in;
         hl5_ff  <= hl5_in;
         ll5_ff  <= ll5_in;
      end
   end

   // Stage 6: radicand x*x - 1.0 in 64 fraction bits.
   hdc_ctl_type ctl6_ff;
   logic [ARG_W-1:0] arg6_ff;
   logic [X_W-1:0] x6_ff;
   logic big6_ff;
   logic [RAD_W-1:0] rad6_in, rad6_ff;

   always_comb begin
      rad6_in = (RAD_W'(hh5_ff) << 64) + (RAD_W'(hl5_ff) << 33) + RAD_W'(ll5_ff)
              - (RAD_W'(1) << 64);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl6_ff <= '0;
      end else if (en) begin
         ctl6_ff <= ctl5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         arg6_ff <= arg5_ff;
         x6_ff   <= x5_ff;
         big6_ff <= big5_ff;
         rad6_ff <= rad6_in;
      end
   end

   assign out_ctl = ctl6_ff;
   assign out_arg = arg6_ff;
   assign out_x   = x6_ff;
   assign out_big = big6_ff;
   assign out_rad = rad6_ff;

endmodule

FILE: rtl/core/hdc_isqrt.sv
// Pipelined restoring square root, one result bit per stage.
module hdc_isqrt
   import hdc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  hdc_ctl_type       in_ctl,
   input  logic [RAD_W-1:0]  in_rad,
   input  logic [ARG_W-1:0]  in_arg,
   input  logic [X_W-1:0]    in_x,
   input  logic              in_big,
   output hdc_ctl_type       out_ctl,
   output logic [X_W-1:0]    out_root,
   output logic [ARG_W-1:0]  out_arg,
   output logic [X_W-1:0]    out_x,
   output logic              out_big
);

   hdc_ctl_type      ctl_w  [X_W+1];
   logic [RAD_W-1:0] rem_w  [X_W+1];
   logic [X_W-1:0]   root_w [X_W+1];
   logic [ARG_W-1:0] arg_w  [X_W+1];
   logic [X_W-1:0]   x_w    [X_W+1];
   logic             big_w  [X_W+1];

   assign ctl_w[0]  = in_ctl;
   assign rem_w[0]  = in_rad;
   assign root_w[0] = '0;
   assign arg_w[0]  = in_arg;
   assign x_w[0]    = in_x;
   assign big_w[0]  = in_big;

   for (genvar k = 0; k < X_W; k++) begin : g_bit
      localparam int B = X_W - 1 - k;
      logic [RAD_W-1:0] trial, rem_in, rem_ff;
      logic [X_W-1:0] root_in, root_ff, x_ff;
      logic [ARG_W-1:0] arg_ff;
      logic big_ff, fit;
      hdc_ctl_type ctl_ff;

      // (r + 2^B)^2 - r^2 = r * 2^(B+1) + 2^(2B)
      always_comb begin
         trial   = (RAD_W'(root_w[k]) << (B + 1)) + (RAD_W'(1) << (2 * B));
         fit     = (trial <= rem_w[k]);
         rem_in  = fit ? (rem_w[k] - trial) : rem_w[k];
         root_in = fit ? (root_w[k] | (X_W'(1) << B)) : root_w[k];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff <= '0;
         end else if (en) begin
            ctl_ff <= ctl_w[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff  <= rem_in;
            root_ff <= root_in;
            arg_ff  <= arg_w[k];
            x_ff    <= x_w[k];
            big_ff  <= big_w[k];
         end
      end

      assign ctl_w[k+1]  = ctl_ff;
      assign rem_w[k+1]  = rem_ff;
      assign root_w[k+1] = root_ff;
      assign arg_w[k+1]  = arg_ff;
      assign x_w[k+1]    = x_ff;
      assign big_w[k+1]  = big_ff;
   end

   assign out_ctl  = ctl_w[X_W];
   assign out_root = root_w[X_W];
   assign out_arg  = arg_w[X_W];
   assign out_x    = x_w[X_W];
   assign out_big  = big_w[X_W];

endmodule

FILE: rtl/core/hdc_log2.sv
// Pipelined base-2 logarithm: normalization, then one squaring per fraction bit.
module hdc_log2
   import hdc_pkg::*;
#(
   parameter int FRAC_BITS = HDC_FRAC_BITS
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  hdc_ctl_type       in_ctl,
   input  logic [X_W-1:0]    in_root,
   input  logic [ARG_W-1:0]  in_arg,
   input  logic [X_W-1:0]    in_x,
   input  logic              in_big,
   output hdc_ctl_type       out_ctl,
   output logic [LG_W-1:0]   out_lg
);

   localparam int Q = 2 * FRAC_BITS + 16;
   localparam int NORM_STEPS = 7;

   // Select the value whose logarithm is taken and its binary point.
   hdc_ctl_type ctl0_ff;
   logic [ARG_W-1:0] v0_in, v0_ff;
   logic [LOG_INT_W-1:0] off0_in, off0_ff;

   always_comb begin
      v0_in   = in_big ? in_arg : (ARG_W'(in_x) + ARG_W'(in_root));
      off0_in = in_big ? LOG_INT_W'(Q - 1) : LOG_INT_W'(SMALL_OFF);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl0_ff <= '0;
      end else if (en) begin
         ctl0_ff <= in_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         v0_ff   <= v0_in;
         off0_ff <= off0_in;
      end
   end

   // Leading-zero normalization, one shift size per stage.
   hdc_ctl_type          nctl_w [NORM_STEPS+1];
   logic [ARG_W-1:0]     nv_w   [NORM_STEPS+1];
   logic [LOG_INT_W-1:0] ncnt_w [NORM_STEPS+1];
   logic [LOG_INT_W-1:0] noff_w [NORM_STEPS+1];

   assign nctl_w[0] = ctl0_ff;
   assign nv_w[0]   = v0_ff;
   assign ncnt_w[0] = '0;
   assign noff_w[0] = off0_ff;

   for (genvar j = 0; j < NORM_STEPS; j++) begin : g_norm
      localparam int SH = 64 >> j;
      hdc_ctl_type ctl_ff;
      logic [ARG_W-1:0] v_in, v_ff;
      logic [LOG_INT_W-1:0] cnt_in, cnt_ff, off_ff;

      always_comb begin
         if (nv_w[j][ARG_W-1 -: SH] == '0) begin
            v_in   = nv_w[j] << SH;
            cnt_in = ncnt_w[j] + LOG_INT_W'(SH);
         end else begin
            v_in   = nv_w[j];
            cnt_in = ncnt_w[j];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff <= '0;
         end else if (en) begin
            ctl_ff <= nctl_w[j];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            v_ff   <= v_in;
            cnt_ff <= cnt_in;
            off_ff <= noff_w[j];
         end
      end

      assign nctl_w[j+1] = ctl_ff;
      assign nv_w[j+1]   = v_ff;
      assign ncnt_w[j+1] = cnt_ff;
      assign noff_w[j+1] = off_ff;
   end

   // Integer part of the logarithm and the mantissa in [1, 2).
   hdc_ctl_type ctle_ff;
   logic [LOG_INT_W-1:0] e_in, e_ff;
   logic [MANT_W-1:0] me_in, me_ff;

   always_comb begin
      e_in  = LOG_INT_W'(ARG_W - 1) - ncnt_w[NORM_STEPS] - noff_w[NORM_STEPS];
      me_in = nv_w[NORM_STEPS][ARG_W-1 -: MANT_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctle_ff <= '0;
      end else if (en) begin
         ctle_ff <= nctl_w[NORM_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e_ff  <= e_in;
         me_ff <= me_in;
      end
   end

   // Fraction bits: square, and renormalize when the square reaches 2.
   hdc_ctl_type          lctl_w [LOG_FRAC+1];
   logic [MANT_W-1:0]    lm_w   [LOG_FRAC+1];
   logic [LOG_FRAC-1:0]  lr_w   [LOG_FRAC+1];
   logic [LOG_INT_W-1:0] le_w   [LOG_FRAC+1];

   assign lctl_w[0] = ctle_ff;
   assign lm_w[0]   = me_ff;
   assign lr_w[0]   = '0;
   assign le_w[0]   = e_ff;

   for (genvar i = 0; i < LOG_FRAC; i++) begin : g_sq
      localparam int BIT = LOG_FRAC - 1 - i;
      hdc_ctl_type ctla_ff, ctlb_ff;
      logic [61:0] hh_in, hh_ff;
      logic [62:0] hl_in, hl_ff;
      logic [63:0] ll_in, ll_ff;
      logic [LOG_FRAC-1:0] ra_ff, rb_in, rb_ff;
      logic [LOG_INT_W-1:0] ea_ff, eb_ff;
      logic [2*MANT_W-1:0] sq;
      logic [63:0] mm;
      logic [MANT_W-1:0] mb_in, mb_ff;

      always_comb begin
         hh_in = 62'(lm_w[i][MANT_W-1:32]) * 62'(lm_w[i][MANT_W-1:32]);
         hl_in = 63'(lm_w[i][MANT_W-1:32]) * 63'(lm_w[i][31:0]);
         ll_in = 64'(lm_w[i][31:0]) * 64'(lm_w[i][31:0]);
      end

      always_comb begin
         sq = ((2*MANT_W)'(hh_ff) << 64) + ((2*MANT_W)'(hl_ff) << 33)
            + (2*MANT_W)'(ll_ff);
         mm = sq[2*MANT_W-1 -: 64];
         mb_in = mm[63] ? mm[63:1] : mm[MANT_W-1:0];
         rb_in = mm[63] ? (ra_ff | (LOG_FRAC'(1) << BIT)) : ra_ff;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctla_ff <= '0;
            ctlb_ff <= '0;
         end else if (en) begin
            ctla_ff <= lctl_w[i];
            ctlb_ff <= ctla_ff;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            hh_ff <= hh_in;
            hl_ff <= hl_in;
            ll_ff <= ll_in;
            ra_ff <= lr_w[i];
            ea_ff <= le_w[i];
            mb_ff <= mb_in;
            rb_ff <= rb_in;
            eb_ff <= ea_ff;
         end
      end

      assign lctl_w[i+1] = ctlb_ff;
      assign lm_w[i+1]   = mb_ff;
      assign lr_w[i+1]   = rb_ff;
      assign le_w[i+1]   = eb_ff;
   end

   assign out_ctl = lctl_w[LOG_FRAC];
   assign out_lg  = {le_w[LOG_FRAC], lr_w[LOG_FRAC]};

endmodule

FILE: rtl/core/hdc_dist.sv
// Natural log, its square, and the bit-serial search for the scaled distance.
module hdc_dist
   import hdc_pkg::*;
#(
   parameter int FRAC_BITS = HDC_FRAC_BITS
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic [CURV_W-1:0]  curv,
   input  hdc_ctl_type        in_ctl,
   input  logic [LG_W-1:0]    in_lg,
   output hdc_ctl_type        out_ctl,
   output logic [DIST_W-1:0]  out_dist
);

   localparam int SQ_W   = 2 * LG_W;
   localparam int T_SH   = 64 - 2 * FRAC_BITS;
   localparam int T_W    = SQ_W - T_SH;
   localparam int SRCH_W = 2 * DIST_W + CURV_W;
   localparam int DC_W   = DIST_W + CURV_W;
   localparam int HI_W   = LG_W - 32;

   // Stage 1: log2 times ln 2, two partial products.
   hdc_ctl_type ctl1_ff;
   logic [LG_W-1:0] p1_in, p1_ff;
   logic [63:0] p0_in, p0_ff;

   always_comb begin
      p1_in = LG_W'(in_lg[LG_W-1:32]) * LG_W'(LN2_Q32);
      p0_in = 64'(in_lg[31:0]) * 64'(LN2_Q32);
   end

   // Stage 2: ln with 40 fraction bits.
   hdc_ctl_type ctl2_ff;
   logic [LG_W-1:0] ln_in, ln_ff;

   assign ln_in = p1_ff + LG_W'(p0_ff[63:32]);

   // Stage 3: partial products of ln squared.
   hdc_ctl_type ctl3_ff;
   logic [2*HI_W-1:0] hh_in, hh_ff;
   logic [LG_W-1:0] hl_in, hl_ff;
   logic [63:0] ll_in, ll_ff;

   always_comb begin
      hh_in = (2*HI_W)'(ln_ff[LG_W-1:32]) * (2*HI_W)'(ln_ff[LG_W-1:32]);
      hl_in = LG_W'(ln_ff[LG_W-1:32]) * LG_W'(ln_ff[31:0]);
      ll_in = 64'(ln_ff[31:0]) * 64'(ln_ff[31:0]);
   end

   // Stage 4: target for d*d*c.
   hdc_ctl_type ctl4_ff;
   logic [SQ_W-1:0] sq;
   logic [T_W-1:0] t_in, t_ff;

   always_comb begin
      sq   = (SQ_W'(hh_ff) << 64) + (SQ_W'(hl_ff) << 33) + SQ_W'(ll_ff);
      t_in = T_W'(sq >> T_SH);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
         ctl3_ff <= '0;
         ctl4_ff <= '0;
      end else if (en) begin
         ctl1_ff <= in_ctl;
         ctl2_ff <= ctl1_ff;
         ctl3_ff <= ctl2_ff;
         ctl4_ff <= ctl3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_ff <= p1_in;
         p0_ff <= p0_in;
         ln_ff <= ln_in;
         hh_ff <= hh_in;
         hl_ff <= hl_in;
         ll_ff <= ll_in;
         t_ff  <= t_in;
      end
   end

   // Search stages: acc = d*d*c and dc = d*c are kept up to date by adds.
   hdc_ctl_type       sctl_w [DIST_W+1];
   logic [SRCH_W-1:0] acc_w  [DIST_W+1];
   logic [DC_W-1:0]   dc_w   [DIST_W+1];
   logic [DIST_W-1:0] d_w    [DIST_W+1];
   logic [T_W-1:0]    t_w    [DIST_W+1];

   assign sctl_w[0] = ctl4_ff;
   assign acc_w[0]  = '0;
   assign dc_w[0]   = '0;
   assign d_w[0]    = '0;
   assign t_w[0]    = t_ff;

   for (genvar k = 0; k < DIST_W; k++) begin : g_bit
      localparam int B = DIST_W - 1 - k;
      hdc_ctl_type ctl_ff;
      logic [SRCH_W-1:0] cand, acc_in, acc_ff;
      logic [DC_W-1:0] dc_in, dc_ff;
      logic [DIST_W-1:0] d_in, d_ff;
      logic [T_W-1:0] t_stage_ff;
      logic fit;

      always_comb begin
         cand   = acc_w[k] + (SRCH_W'(dc_w[k]) << (B + 1)) + (SRCH_W'(curv) << (2 * B));
         fit    = (cand <= SRCH_W'(t_w[k]));
         acc_in = fit ? cand : acc_w[k];
         dc_in  = fit ? (dc_w[k] + (DC_W'(curv) << B)) : dc_w[k];
         d_in   = fit ? (d_w[k] | (DIST_W'(1) << B)) : d_w[k];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff <= '0;
         end else if (en) begin
            ctl_ff <= sctl_w[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            acc_ff     <= acc_in;
            dc_ff      <= dc_in;
            d_ff       <= d_in;
            t_stage_ff <= t_w[k];
         end
      end

      assign sctl_w[k+1] = ctl_ff;
      assign acc_w[k+1]  = acc_ff;
      assign dc_w[k+1]   = dc_ff;
      assign d_w[k+1]    = d_ff;
      assign t_w[k+1]    = t_stage_ff;
   end

   assign out_ctl  = sctl_w[DIST_W];
   assign out_dist = d_w[DIST_W];

endmodule

FILE: rtl/core/hyperboloid_distance_core.sv
// Top level of the hyperboloid-model distance core.
//
// Each request transfer carries two points (x, y, z) in signed fixed point with
// FRAC_BITS fraction bits, z being the time-like axis. Each request yields
// exactly one response: the distance r*acosh(-<p1,p2>/r^2) in unsigned fixed
// point, rounded down and saturated at all ones, plus a not_hyperbolic flag.
// The curvature magnitude is written through csr_write_enable/csr_write_data
// (unsigned Q8.16) while no request is in flight. A zero curvature returns a
// distance of zero with not_hyperbolic set.
//
// The datapath is a 187-stage pipeline: argument formation (6), square root of
// x*x - 1 (56, one bit each), normalization and log2 by repeated squaring
// (89, two stages per fraction bit), and the ln, square and distance search
// (36). One request can be taken in every cycle while req_ready is high.
//
// Reset clears all valid bits and loads a curvature of 1.0. When the receiver
// stalls, the response register holds and one more result lands in a skid
// register; only then does req_ready fall and the whole pipeline freeze.
module hyperboloid_distance_core
   import hdc_pkg::*;
#(
   parameter int FRAC_BITS = HDC_FRAC_BITS
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [COORD_W-1:0]  req_first_x,
   input  logic signed [COORD_W-1:0]  req_first_y,
   input  logic signed [COORD_W-1:0]  req_first_z,
   input  logic signed [COORD_W-1:0]  req_second_x,
   input  logic signed [COORD_W-1:0]  req_second_y,
   input  logic signed [COORD_W-1:0]  req_second_z,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [DIST_W-1:0]          rsp_distance,
   output logic                       rsp_not_hyperbolic,
   input  logic                       csr_write_enable,
   input  logic [CURV_W-1:0]          csr_write_data
);

   // Curvature; the user, not the core, keeps it stable with items in flight.
   logic [CURV_W-1:0] curv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         curv_ff <= CURV_RESET;
      end else if (csr_write_enable) begin
         curv_ff <= csr_write_data;
      end
   end

   // The pipeline advances whenever the skid register is free.
   logic en;
   logic sk_v_ff;

   assign en        = !sk_v_ff;
   assign req_ready = en;

   hdc_ctl_type a_ctl, s_ctl, l_ctl, d_ctl;
   logic [ARG_W-1:0] a_arg, s_arg;
   logic [X_W-1:0] a_x, s_x, s_root;
   logic a_big, s_big;
   logic [RAD_W-1:0] a_rad;
   logic [LG_W-1:0] l_lg;
   logic [DIST_W-1:0] d_dist;

   hdc_arg #(.FRAC_BITS(FRAC_BITS)) u_arg (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .curv     (curv_ff),
      .in_valid (req_valid),
      .first_x  (req_first_x),
      .first_y  (req_first_y),
      .first_z  (req_first_z),
      .second_x (req_second_x),
      .second_y (req_second_y),
      .second_z (req_second_z),
      .out_ctl  (a_ctl),
      .out_arg  (a_arg),
      .out_x    (a_x),
      .out_big  (a_big),
      .out_rad  (a_rad)
   );

   hdc_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_ctl   (a_ctl),
      .in_rad   (a_rad),
      .in_arg   (a_arg),
      .in_x     (a_x),
      .in_big   (a_big),
      .out_ctl  (s_ctl),
      .out_root (s_root),
      .out_arg  (s_arg),
      .out_x    (s_x),
      .out_big  (s_big)
   );

   hdc_log2 #(.FRAC_BITS(FRAC_BITS)) u_log2 (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_ctl  (s_ctl),
      .in_root (s_root),
      .in_arg  (s_arg),
      .in_x    (s_x),
      .in_big  (s_big),
      .out_ctl (l_ctl),
      .out_lg  (l_lg)
   );

   hdc_dist #(.FRAC_BITS(FRAC_BITS)) u_dist (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .curv     (curv_ff),
      .in_ctl   (l_ctl),
      .in_lg    (l_lg),
      .out_ctl  (d_ctl),
      .out_dist (d_dist)
   );

   // Final result: forced to zero for a degenerate argument or zero curvature.
   logic [DIST_W-1:0] res_dist;
   assign res_dist = d_ctl.zero ? '0 : d_dist;

   // Response register plus one skid entry.
   logic out_v_in, out_v_ff, sk_v_in;
   logic [DIST_W-1:0] out_d_in, out_d_ff, sk_d_in, sk_d_ff;
   logic out_nh_in, out_nh_ff, sk_nh_in, sk_nh_ff;
   logic take;

   always_comb begin
      take      = !out_v_ff || rsp_ready;
      out_v_in  = out_v_ff;
      out_d_in  = out_d_ff;
      out_nh_in = out_nh_ff;
      sk_v_in   = sk_v_ff;
      sk_d_in   = sk_d_ff;
      sk_nh_in  = sk_nh_ff;
      if (take) begin
         if (sk_v_ff) begin
            // The pipeline is frozen; drain the skid entry first.
            out_v_in  = 1'b1;
            out_d_in  = sk_d_ff;
            out_nh_in = sk_nh_ff;
            sk_v_in   = 1'b0;
         end else begin
            out_v_in  = d_ctl.valid;
            out_d_in  = res_dist;
            out_nh_in = d_ctl.nh;
         end
      end else if (en && d_ctl.valid) begin
         sk_v_in  = 1'b1;
         sk_d_in  = res_dist;
         sk_nh_in = d_ctl.nh;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
         sk_v_ff  <= 1'b0;
      end else begin
         out_v_ff <= out_v_in;
         sk_v_ff  <= sk_v_in;
      end
   end

   always_ff @(posedge clock) begin
      out_d_ff  <= out_d_in;
      out_nh_ff <= out_nh_in;
      sk_d_ff   <= sk_d_in;
      sk_nh_ff  <= sk_nh_in;
   end

   assign rsp_valid          = out_v_ff;
   assign rsp_distance       = out_d_ff;
   assign rsp_not_hyperbolic = out_nh_ff;

   // The skid entry is only ever filled behind a waiting response.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      sk_v_ff |-> out_v_ff)
      else $error("skid entry valid without a pending response");

   // A non-hyperbolic result always carries a zero distance.
   a_nh_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_not_hyperbolic) |-> (rsp_distance == '0))
      else $error("not_hyperbolic response with nonzero distance");

   // A held skid entry is neither lost nor changed while the receiver stalls.
   a_skid_hold: assert property (@(posedge clock) disable iff (reset)
      (sk_v_ff && !rsp_ready) |=> (sk_v_ff && $stable(sk_d_ff) && $stable(sk_nh_ff)))
      else $error("skid entry lost during stall");

   // Reset empties the output side and opens the request side.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("outputs not cleared by reset");

endmodule
